FILE: rtl/kcre_pkg.sv
// ----------------------------------------------------------------------------
// kcre_pkg
// Shared types and constants of the key color run encoder.
// ----------------------------------------------------------------------------
package kcre_pkg;

  localparam int unsigned MAX_LINE    = 4096;
  localparam int unsigned IDX_W       = $clog2(MAX_LINE);
  localparam int unsigned OFF_W       = 12;
  localparam int unsigned PIX_W       = 32;
  localparam int unsigned CFG_IDX_W   = 8;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  localparam logic [PIX_W-1:0] RGB_MASK = 32'h00FF_FFFF;

  localparam logic [CFG_IDX_W-1:0] REG_KEY_COLOR     = 8'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COMPARE_ALPHA = 8'd1;

  typedef logic [IDX_W-1:0] index_t;
  typedef logic [OFF_W-1:0] offset_t;
  typedef logic [PIX_W-1:0] pixel_t;

  typedef struct packed {
    pixel_t  pixel;
    logic    run_start;
    offset_t run_offset;
    logic    run_end;
    logic    line_end;
  } result_t;

  // one entry per input beat that yields results: held pixel first, then
  // the line-closing pixel
  typedef struct packed {
    logic    a_valid;
    result_t a;
    logic    b_valid;
    result_t b;
  } entry_t;

  typedef struct packed {
    logic   valid;
    entry_t entry;
  } head_t;

endpackage

FILE: rtl/kcre_front.sv
// ----------------------------------------------------------------------------
// kcre_front
// Accepts pixels, compares them with the key color, tracks run state and
// pushes the results that each beat releases.
// ----------------------------------------------------------------------------
module kcre_front (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [kcre_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  logic [31:0]                      cfg_data_i,
  input  logic                             s_axis_tvalid,
  output logic                             s_axis_tready,
  input  logic [31:0]                      s_axis_tdata,  // pixel[31:0]
  input  logic                             s_axis_tlast,  // last_in_line
  input  logic                             full_i,
  output logic                             push_o,
  output kcre_pkg::entry_t                 push_entry_o
);

  kcre_pkg::pixel_t  key_color_q;
  logic              compare_alpha_q;
  kcre_pkg::pixel_t  held_pixel_q, held_pixel_d;
  logic              held_valid_q, held_valid_d;
  logic              held_start_q, held_start_d;
  kcre_pkg::offset_t held_offset_q, held_offset_d;
  kcre_pkg::index_t  pixel_index_q, pixel_index_d;
  kcre_pkg::index_t  prev_last_q, prev_last_d;

  kcre_pkg::pixel_t  mask;
  logic              is_key;
  logic              accept;
  logic              start;
  kcre_pkg::offset_t off;

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = !full_i;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign mask   = compare_alpha_q ? '1 : kcre_pkg::RGB_MASK;
  assign is_key = ((s_axis_tdata ^ key_color_q) & mask) == '0;
  assign start  = !held_valid_q;
  assign off    = start ? (kcre_pkg::offset_t'(pixel_index_q)
                           - kcre_pkg::offset_t'(prev_last_q)) : '0;

  always_comb begin
    push_entry_o.a_valid      = held_valid_q;
    push_entry_o.a.pixel      = held_pixel_q;
    push_entry_o.a.run_start  = held_start_q;
    push_entry_o.a.run_offset = held_offset_q;
    push_entry_o.a.run_end    = is_key;
    push_entry_o.a.line_end   = is_key && s_axis_tlast;
    push_entry_o.b_valid      = !is_key && s_axis_tlast;
    push_entry_o.b.pixel      = s_axis_tdata;
    push_entry_o.b.run_start  = start;
    push_entry_o.b.run_offset = off;
    push_entry_o.b.run_end    = 1'b1;
    push_entry_o.b.line_end   = 1'b1;
  end

  assign push_o = accept && (push_entry_o.a_valid || push_entry_o.b_valid);

  always_comb begin
    held_pixel_d  = held_pixel_q;
    held_valid_d  = held_valid_q;
    held_start_d  = held_start_q;
    held_offset_d = held_offset_q;
    pixel_index_d = pixel_index_q;
    prev_last_d   = prev_last_q;
    if (accept) begin
      held_valid_d = !is_key && !s_axis_tlast;
      if (!is_key) begin
        prev_last_d   = pixel_index_q;
        held_pixel_d  = s_axis_tdata;
        held_start_d  = start;
        held_offset_d = off;
      end
      if (s_axis_tlast) begin
        pixel_index_d = '0;
        prev_last_d   = '0;
        held_start_d  = 1'b0;
        held_offset_d = '0;
        held_pixel_d  = '0;
      end else if (pixel_index_q == kcre_pkg::index_t'(kcre_pkg::MAX_LINE - 1)) begin
        pixel_index_d = '0;
      end else begin
        pixel_index_d = pixel_index_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      key_color_q     <= '0;
      compare_alpha_q <= 1'b1;
      held_pixel_q    <= '0;
      held_valid_q    <= 1'b0;
      held_start_q    <= 1'b0;
      held_offset_q   <= '0;
      pixel_index_q   <= '0;
      prev_last_q     <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          kcre_pkg::REG_KEY_COLOR:     key_color_q     <= cfg_data_i;
          kcre_pkg::REG_COMPARE_ALPHA: compare_alpha_q <= cfg_data_i[0];
          default: ;
        endcase
      end
      held_pixel_q  <= held_pixel_d;
      held_valid_q  <= held_valid_d;
      held_start_q  <= held_start_d;
      held_offset_q <= held_offset_d;
      pixel_index_q <= pixel_index_d;
      prev_last_q   <= prev_last_d;
    end
  end

endmodule

FILE: rtl/kcre_queue.sv
// ----------------------------------------------------------------------------
// kcre_queue
// Short show-ahead queue of result entries between front and back.
// ----------------------------------------------------------------------------
module kcre_queue (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  kcre_pkg::entry_t push_entry_i,
  output logic             full_o,
  input  logic             pop_i,
  output kcre_pkg::head_t  head_o
);

  kcre_pkg::entry_t              store_q [kcre_pkg::QUEUE_DEPTH];
  logic [kcre_pkg::QPTR_W-1:0]   wr_ptr_q, rd_ptr_q;
  logic [kcre_pkg::QCNT_W-1:0]   count_q;
  logic                          do_pop;

  assign full_o       = count_q == kcre_pkg::QCNT_W'(kcre_pkg::QUEUE_DEPTH);
  assign head_o.valid = count_q != '0;
  assign head_o.entry = store_q[rd_ptr_q];
  assign do_pop       = pop_i && head_o.valid;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      store_q[wr_ptr_q] <= push_entry_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, do_pop})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

FILE: rtl/kcre_back.sv
// ----------------------------------------------------------------------------
// kcre_back
// Splits queue entries into result beats and drives the output register.
// ----------------------------------------------------------------------------
module kcre_back (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  kcre_pkg::head_t head_i,
  output logic            pop_o,
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [47:0]     m_axis_tdata,  // out_pixel[31:0], run_offset[43:32], zero pad
  output logic [1:0]      m_axis_tuser,  // run_start[0], run_end[1]
  output logic            m_axis_tlast   // line_end
);

  logic              out_valid_q;
  kcre_pkg::result_t out_q, out_d;
  logic              phase_q, phase_d;
  logic              load;
  logic              take_a;

  assign load   = head_i.valid && (!out_valid_q || m_axis_tready);
  assign take_a = head_i.entry.a_valid && !phase_q;

  always_comb begin
    out_d   = take_a ? head_i.entry.a : head_i.entry.b;
    pop_o   = 1'b0;
    phase_d = phase_q;
    if (load) begin
      if (take_a && head_i.entry.b_valid) begin
        phase_d = 1'b1;
      end else begin
        pop_o   = 1'b1;
        phase_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      phase_q     <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0, out_q.run_offset, out_q.pixel};
  assign m_axis_tuser  = {out_q.run_end, out_q.run_start};
  assign m_axis_tlast  = out_q.line_end;

endmodule

FILE: rtl/key_color_run_encoder_core.sv
// ----------------------------------------------------------------------------
// key_color_run_encoder_core
// Color key run encoder: splits scan lines into runs of non-key pixels.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one ARGB pixel per beat, tlast on the last pixel of a line.
//   m_axis carries each non-key pixel once; tuser flags run start and run
//   end, tdata holds the pixel and the run offset, tlast marks line end.
//   cfg writes key_color (index 0) and compare_alpha (index 1); always ready,
//   write only while the block is idle.
// Throughput: one pixel per cycle while the queue is not full. A line ending on
//   a non-key pixel right after another non-key pixel yields two beats, which the
//   back end sends one after the other; the four-entry queue absorbs this.
// Path: a pixel is held until the next pixel shows whether it ends its
//   run, then goes from that beat through the queue into the output
//   register and onto m_axis.
// Reset: clears run state, queue and output; key_color 0, compare_alpha 1.
// Stall: a stalled m_axis holds its beat; s_axis tready drops once the
//   queue fills.
// ----------------------------------------------------------------------------
module key_color_run_encoder_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kcre_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [31:0]                    cfg_data_i,
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  input  logic [31:0]                    s_axis_tdata,  // pixel[31:0]
  input  logic                           s_axis_tlast,  // last_in_line
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  output logic [47:0]                    m_axis_tdata,  // out_pixel[31:0], run_offset[43:32]
  output logic [1:0]                     m_axis_tuser,  // run_start[0], run_end[1]
  output logic                           m_axis_tlast   // line_end
);

  logic             push;
  kcre_pkg::entry_t push_entry;
  logic             full;
  logic             pop;
  kcre_pkg::head_t  head;

  kcre_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_ready_o   (cfg_ready_o),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .full_i        (full),
    .push_o        (push),
    .push_entry_o  (push_entry)
  );

  kcre_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_entry_i (push_entry),
    .full_o       (full),
    .pop_i        (pop),
    .head_o       (head)
  );

  kcre_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_i        (head),
    .pop_o         (pop),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

FILE: tb/tb_key_color_run_encoder_core.sv
// ----------------------------------------------------------------------------
// tb_key_color_run_encoder_core
// Self-checking testbench for the color key run encoder.
// A built-in model splits every accepted pixel into run beats and queues them.
// Each output beat is checked against the oldest queued beat. Directed lines
// come first. Random lines follow under several key settings and idle
// patterns, and a long output hold-off at the end makes the encoder stall
// its input.
// ----------------------------------------------------------------------------
module tb_key_color_run_encoder_core;
  import kcre_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 8'd2;
  localparam int DRAIN_CYCLES = 8;
  localparam int MAX_REPORTS  = 10;

  logic                 clk_i         = 1'b0;
  logic                 rst_ni        = 1'b0;
  logic                 cfg_valid_i   = 1'b0;
  logic                 cfg_ready_o;
  logic [CFG_IDX_W-1:0] cfg_index_i   = '0;
  logic [31:0]          cfg_data_i    = '0;
  logic                 s_axis_tvalid = 1'b0;
  logic                 s_axis_tready;
  logic [31:0]          s_axis_tdata  = '0;
  logic                 s_axis_tlast  = 1'b0;
  logic                 m_axis_tvalid;
  logic                 m_axis_tready = 1'b0;
  logic [47:0]          m_axis_tdata;
  logic [1:0]           m_axis_tuser;
  logic                 m_axis_tlast;

  key_color_run_encoder_core u_top (.*);

  // encoder model state
  pixel_t  key_color     = '0;
  logic    compare_alpha = 1'b1;
  pixel_t  held_pixel    = '0;
  logic    held_valid    = 1'b0;
  logic    held_start    = 1'b0;
  offset_t held_offset   = '0;
  index_t  pixel_index   = '0;
  index_t  prev_run_last = '0;

  result_t expected_beats[$];

  int tx_idle_pct   = 0;
  int rx_stall_pct  = 0;
  int hold_req      = 0;
  int errors        = 0;
  int beats_checked = 0;
  int pixels_sent   = 0;
  int lines_sent    = 0;
  int input_stalls  = 0;

  initial forever #5 clk_i = ~clk_i;

  function automatic logic is_key_pixel(pixel_t px);
    pixel_t mask;
    mask = compare_alpha ? '1 : RGB_MASK;
    return ((px ^ key_color) & mask) == '0;
  endfunction

  function automatic void queue_beat(pixel_t px, logic start, offset_t off,
                                     logic run_end, logic line_end);
    result_t r;
    r.pixel      = px;
    r.run_start  = start;
    r.run_offset = start ? off : '0;
    r.run_end    = run_end;
    r.line_end   = line_end;
    expected_beats.insert(expected_beats.size(), r);
  endfunction

  function automatic void encode_pixel(pixel_t px, logic last);
    logic    key;
    logic    start;
    offset_t off;
    key   = is_key_pixel(px);
    start = !held_valid;
    off   = '0;
    if (held_valid) begin
      queue_beat(held_pixel, held_start, held_offset, key, key && last);
      held_valid = 1'b0;
    end
    if (!key) begin
      if (start) off = offset_t'(pixel_index - prev_run_last);
      prev_run_last = pixel_index;
      if (last) begin
        queue_beat(px, start, off, 1'b1, 1'b1);
      end else begin
        held_pixel  = px;
        held_valid  = 1'b1;
        held_start  = start;
        held_offset = off;
      end
    end
    if (last) begin
      pixel_index   = '0;
      prev_run_last = '0;
      held_valid    = 1'b0;
      held_start    = 1'b0;
      held_offset   = '0;
      held_pixel    = '0;
    end else if (int'(pixel_index) + 1 >= int'(MAX_LINE)) begin
      pixel_index = '0;
    end else begin
      pixel_index = pixel_index + 1'b1;
    end
  endfunction

  function automatic pixel_t random_pixel(int key_pct);
    int roll;
    roll = $urandom_range(99);
    if (roll < key_pct)
      return compare_alpha ? key_color : {8'($urandom), key_color[23:0]};
    if (roll < key_pct + 8) return key_color ^ (32'h1 << $urandom_range(31));
    return $urandom;
  endfunction

  task automatic send_pixel(pixel_t px, logic last);
    if ($urandom_range(99) < tx_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < tx_idle_pct);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= px;
    s_axis_tlast  <= last;
    @(posedge clk_i);
    while (!s_axis_tready) begin
      input_stalls++;
      @(posedge clk_i);
    end
    encode_pixel(px, last);
    pixels_sent++;
    if (last) lines_sent++;
  endtask

  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= data;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    if (idx == REG_KEY_COLOR) key_color = data;
    else if (idx == REG_COMPARE_ALPHA) compare_alpha = data[0];
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain;
    s_axis_tvalid <= 1'b0;
    while (expected_beats.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  function automatic void report_mismatch(string what, longint unsigned want,
                                          longint unsigned got);
    errors++;
    if (errors <= MAX_REPORTS)
      $display("mismatch %s: expected %0h got %0h", what, want, got);
  endfunction

  // output side: random stalls, plus a counted hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    forever begin
      @(posedge clk_i);
      if (hold_req != 0) begin
        hold_left = hold_req;
        hold_req  = 0;
      end
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= rx_stall_pct);
      end
    end
  end

  always @(posedge clk_i) begin : check_beat
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      beats_checked++;
      if (expected_beats.size() == 0) begin
        report_mismatch("beat with none pending, pixel", 0, m_axis_tdata[PIX_W-1:0]);
      end else begin
        want = expected_beats.pop_front();
        if (m_axis_tdata[PIX_W-1:0] !== want.pixel)
          report_mismatch("out_pixel", want.pixel, m_axis_tdata[PIX_W-1:0]);
        if (m_axis_tdata[PIX_W +: OFF_W] !== want.run_offset)
          report_mismatch("run_offset", want.run_offset, m_axis_tdata[PIX_W +: OFF_W]);
        if (m_axis_tuser[0] !== want.run_start)
          report_mismatch("run_start", want.run_start, m_axis_tuser[0]);
        if (m_axis_tuser[1] !== want.run_end)
          report_mismatch("run_end", want.run_end, m_axis_tuser[1]);
        if (m_axis_tlast !== want.line_end)
          report_mismatch("line_end", want.line_end, m_axis_tlast);
      end
    end
  end

  task automatic test_directed;
    // all-key line: no beats
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    // two non-key pixels ending the line: two beats on one step
    send_pixel(32'hFFFF_FFFF, 1'b0);
    send_pixel(32'h0000_0001, 1'b1);
    // gaps between runs, held pixel closed by a key pixel at line end
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'hFF00_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h8000_0000, 1'b0);
    send_pixel(32'h7FFF_FFFF, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    // single-pixel line
    send_pixel(32'hA5A5_A5A5, 1'b1);
    send_pixel(32'h0000_0000, 1'b0);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h0000_0000, 1'b1);
    drain();
  endtask

  task automatic test_alpha_mask;
    cfg_write(REG_KEY_COLOR, 32'h1234_5678);
    cfg_write(REG_COMPARE_ALPHA, 32'hFFFF_FFFE);  // only bit 0 counts
    cfg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_pixel(32'hAB34_5678, 1'b0);
    send_pixel(32'h1234_5679, 1'b0);
    send_pixel(32'hFF34_5678, 1'b1);
    send_pixel(32'h1234_5678, 1'b0);
    send_pixel(32'h0034_5678, 1'b1);
    drain();
    cfg_write(REG_COMPARE_ALPHA, 32'h0000_0001);
    send_pixel(32'hAB34_5678, 1'b0);
    send_pixel(32'h1234_5678, 1'b1);
    drain();
  endtask

  task automatic run_phase(pixel_t key, logic cmp, int tx_pct, int rx_pct,
                           int n_items);
    int sent;
    int len;
    int key_pct;
    cfg_write(REG_KEY_COLOR, key);
    cfg_write(REG_COMPARE_ALPHA, {31'd0, cmp});
    tx_idle_pct  = tx_pct;
    rx_stall_pct = rx_pct;
    sent = 0;
    while (sent < n_items) begin
      len     = ($urandom_range(9) == 0) ? 1 : $urandom_range(2, 24);
      key_pct = $urandom_range(80);
      for (int i = 0; i < len; i++) send_pixel(random_pixel(key_pct), i == len - 1);
      sent += len;
    end
    drain();
  endtask

  task automatic test_backpressure;
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    hold_req     = 80;
    for (int i = 0; i < 48; i++) send_pixel(random_pixel(30), (i % 12) == 11);
    drain();
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_alpha_mask();
    run_phase(32'h0000_0000, 1'b1, 0, 0, 165);
    run_phase(32'hFFFF_FFFF, 1'b0, 51, 0, 165);
    run_phase($urandom, 1'b1, 0, 51, 165);
    run_phase($urandom, 1'b0, 23, 23, 165);
    test_backpressure();
    $display("checked %0d output beats from %0d pixels in %0d lines", beats_checked,
             pixels_sent, lines_sent);
    $display("key/alpha settings, line ends and output hold-off (%0d stalls)",
             input_stalls);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #3000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

FILE: key_color_run_encoder_core.f
rtl/kcre_pkg.sv
rtl/kcre_front.sv
rtl/kcre_queue.sv
rtl/kcre_back.sv
rtl/key_color_run_encoder_core.sv
tb/tb_key_color_run_encoder_core.sv
